[hdl/pisep_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisep_pkg
// Shared types, widths, register indexes and reset values of the PID
// controller with integral separation.
// ----------------------------------------------------------------------------
package pisep_pkg;

  // Field and register widths.
  localparam int MeasW   = 16;
  localparam int TargetW = 16;
  localparam int GainW   = 24;
  localparam int ThreshW = 15;
  localparam int ErrW    = 17;
  localparam int DiffW   = 18;
  localparam int IntegW  = 32;
  localparam int DriveW  = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 24;

  // Product and accumulator widths.
  localparam int ProdPW  = GainW + ErrW;
  localparam int ProdDW  = GainW + DiffW;
  localparam int ProdIW  = GainW + IntegW;
  localparam int AccW    = ProdIW + 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegTarget = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainP  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainI  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainD  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegThresh = 3'd4;

  // Reset values: Kp = 50.0 in Q16.8, threshold = 35.0 in Q7.8.
  localparam logic signed [TargetW-1:0] TargetReset = '0;
  localparam logic signed [GainW-1:0]   GainPReset  = 24'sd12800;
  localparam logic signed [GainW-1:0]   GainIReset  = '0;
  localparam logic signed [GainW-1:0]   GainDReset  = '0;
  localparam logic [ThreshW-1:0]        ThreshReset = 15'd8960;

  // Configuration register set.
  typedef struct packed {
    logic signed [TargetW-1:0] target;
    logic signed [GainW-1:0]   gain_p;
    logic signed [GainW-1:0]   gain_i;
    logic signed [GainW-1:0]   gain_d;
    logic [ThreshW-1:0]        threshold;
  } cfg_t;

  // Front stage result: error terms and updated integral.
  typedef struct packed {
    logic signed [ErrW-1:0]   err;
    logic signed [DiffW-1:0]  diff;
    logic signed [IntegW-1:0] integ;
    logic                     dropped;
  } front_t;

  // Multiplier stage result.
  typedef struct packed {
    logic signed [ProdPW-1:0] prod_p;
    logic signed [ProdDW-1:0] prod_d;
    logic signed [ProdIW-1:0] prod_i;
    logic                     dropped;
  } prod_t;

endpackage

[hdl/pisep_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisep_sample_if / pisep_result_if
// Valid/ready channels for measured samples and controller results.
// ----------------------------------------------------------------------------
interface pisep_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pisep_pkg::MeasW-1:0]   measured;

  modport source (output valid, output measured, input ready);
  modport sink (input valid, input measured, output ready);
endinterface

interface pisep_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pisep_pkg::DriveW-1:0]  drive;
  logic                                 integral_dropped;

  modport source (output valid, output drive, output integral_dropped, input ready);
  modport sink (input valid, input drive, input integral_dropped, output ready);
endinterface

[hdl/pid_integral_separation_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_integral_separation_core
// Positional PID controller with integral separation, Q8.8 in and Q24.8 out.
// ----------------------------------------------------------------------------
//  Channel     Dir  Handshake      Payload
//  samples     in   valid/ready    measured (16b signed, Q8.8)
//  results     out  valid/ready    drive (32b signed, Q24.8), integral_dropped
//  cfg_*       in   write enable   cfg_index (3b), cfg_data (24b)
//
//  One word is taken per cycle while the results channel is not stalled; a
//  result passes from its sample through the front, multiplier and output registers.
//  Reset clears the previous error, the integral, all stage valids and loads
//  the configuration defaults (Kp = 50.0, threshold = 35.0).
//  A stalled result holds the output register; empty stages upstream still
//  take new words until the pipeline is full.
// ----------------------------------------------------------------------------
module pid_integral_separation_core (
  input  logic                           clk,
  input  logic                           rst,
  pisep_sample_if.sink                   samples,
  pisep_result_if.source                 results,
  input  logic                           cfg_write,
  input  logic [pisep_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pisep_pkg::CfgDatW-1:0]  cfg_data
);

  pisep_pkg::cfg_t    cfg;
  pisep_pkg::front_t  front;
  pisep_pkg::prod_t   prod;
  logic               front_valid;
  logic               prod_valid;
  logic               mult_ready;
  logic               out_ready;

  // Configuration registers.
  pisep_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Error, integral and separation.
  pisep_front u_front (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .cfg         (cfg),
    .down_ready  (mult_ready),
    .front_valid (front_valid),
    .front       (front)
  );

  // Gain products.
  pisep_mult u_mult (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .front_valid (front_valid),
    .front       (front),
    .up_ready    (mult_ready),
    .down_ready  (out_ready),
    .prod_valid  (prod_valid),
    .prod        (prod)
  );

  // Sum, rescale, saturate and hold.
  pisep_out u_out (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod       (prod),
    .up_ready   (out_ready),
    .results    (results)
  );

endmodule

[hdl/pisep_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisep_cfg
// Configuration register file: setpoint, three gains and separation threshold.
// ----------------------------------------------------------------------------
module pisep_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pisep_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [pisep_pkg::CfgDatW-1:0]       cfg_data,
  output pisep_pkg::cfg_t                     cfg
);

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target    <= pisep_pkg::TargetReset;
      cfg.gain_p    <= pisep_pkg::GainPReset;
      cfg.gain_i    <= pisep_pkg::GainIReset;
      cfg.gain_d    <= pisep_pkg::GainDReset;
      cfg.threshold <= pisep_pkg::ThreshReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pisep_pkg::RegTarget: cfg.target    <= cfg_data[pisep_pkg::TargetW-1:0];
        pisep_pkg::RegGainP:  cfg.gain_p    <= cfg_data;
        pisep_pkg::RegGainI:  cfg.gain_i    <= cfg_data;
        pisep_pkg::RegGainD:  cfg.gain_d    <= cfg_data;
        pisep_pkg::RegThresh: cfg.threshold <= cfg_data[pisep_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hdl/pisep_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisep_front
// Input stage: forms the error, the derivative difference, updates the
// saturating integral and decides integral separation for each word.
// ----------------------------------------------------------------------------
module pisep_front (
  input  logic                   clk,
  input  logic                   rst,
  pisep_sample_if.sink           samples,
  input  pisep_pkg::cfg_t        cfg,
  input  logic                   down_ready,
  output logic                   front_valid,
  output pisep_pkg::front_t      front
);

  logic signed [pisep_pkg::ErrW-1:0]    previous_error;
  logic signed [pisep_pkg::IntegW-1:0]  integral_sum;

  logic signed [pisep_pkg::ErrW-1:0]    err;
  logic signed [pisep_pkg::DiffW-1:0]   diff;
  logic signed [pisep_pkg::IntegW+1:0]  integ_wide;
  logic signed [pisep_pkg::IntegW-1:0]  integral_sum_next;
  logic signed [pisep_pkg::ErrW-1:0]    meas_ext;
  logic signed [pisep_pkg::ErrW-1:0]    thr_pos;
  logic signed [pisep_pkg::ErrW-1:0]    thr_neg;
  logic                                 dropped;
  logic                                 accept;

  assign samples.ready = !front_valid || down_ready;
  assign accept        = samples.valid && samples.ready;

  // Error is setpoint plus measurement, since the sensor sign is inverted.
  always_comb begin
    meas_ext = pisep_pkg::ErrW'(samples.measured);
    err      = pisep_pkg::ErrW'(cfg.target) + meas_ext;
    diff     = pisep_pkg::DiffW'(err) - pisep_pkg::DiffW'(previous_error);
  end

  // The integral accumulates the negated error and saturates to 32 bits.
  always_comb begin
    integ_wide = (pisep_pkg::IntegW+2)'(integral_sum) - (pisep_pkg::IntegW+2)'(err);
    if (integ_wide[pisep_pkg::IntegW+1:pisep_pkg::IntegW-1] == 3'b000 ||
        integ_wide[pisep_pkg::IntegW+1:pisep_pkg::IntegW-1] == 3'b111) begin
      integral_sum_next = integ_wide[pisep_pkg::IntegW-1:0];
    end else if (integ_wide[pisep_pkg::IntegW+1]) begin
      integral_sum_next = {1'b1, {(pisep_pkg::IntegW-1){1'b0}}};
    end else begin
      integral_sum_next = {1'b0, {(pisep_pkg::IntegW-1){1'b1}}};
    end
  end

  // Separation: drop the integral term when |measured| reaches the threshold.
  always_comb begin
    thr_pos = signed'({2'b00, cfg.threshold});
    thr_neg = -thr_pos;
    dropped = (meas_ext >= thr_pos) || (meas_ext <= thr_neg);
  end

  // Controller state and stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integral_sum   <= '0;
      front_valid    <= 1'b0;
    end else begin
      if (samples.ready) begin
        front_valid <= samples.valid;
      end
      if (accept) begin
        previous_error <= err;
        integral_sum   <= integral_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front.err     <= err;
      front.diff    <= diff;
      front.integ   <= integral_sum_next;
      front.dropped <= dropped;
    end
  end

endmodule

[hdl/pisep_mult.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisep_mult
// Multiplier stage: the three gain products, each registered.
// ----------------------------------------------------------------------------
module pisep_mult (
  input  logic                   clk,
  input  logic                   rst,
  input  pisep_pkg::cfg_t        cfg,
  input  logic                   front_valid,
  input  pisep_pkg::front_t      front,
  output logic                   up_ready,
  input  logic                   down_ready,
  output logic                   prod_valid,
  output pisep_pkg::prod_t       prod
);

  logic advance;

  assign up_ready = !prod_valid || down_ready;
  assign advance  = up_ready && front_valid;

  // Stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (up_ready) begin
      prod_valid <= front_valid;
    end
  end

  // Kp*e, Kd*(e - e_prev) and Ki*I, all Q.16.
  always_ff @(posedge clk) begin
    if (advance) begin
      prod.prod_p  <= pisep_pkg::ProdPW'(cfg.gain_p) * pisep_pkg::ProdPW'(front.err);
      prod.prod_d  <= pisep_pkg::ProdDW'(cfg.gain_d) * pisep_pkg::ProdDW'(front.diff);
      prod.prod_i  <= pisep_pkg::ProdIW'(cfg.gain_i) * pisep_pkg::ProdIW'(front.integ);
      prod.dropped <= front.dropped;
    end
  end

endmodule

[hdl/pisep_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisep_out
// Output stage: sums the products, rescales to Q24.8 with floor, saturates
// to 32 bits and holds the result word for the sink.
// ----------------------------------------------------------------------------
module pisep_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   prod_valid,
  input  pisep_pkg::prod_t       prod,
  output logic                   up_ready,
  pisep_result_if.source         results
);

  logic signed [pisep_pkg::AccW-1:0]   acc;
  logic signed [pisep_pkg::DriveW-1:0] drive_next;
  logic                                advance;

  assign up_ready = !results.valid || results.ready;
  assign advance  = up_ready && prod_valid;

  // Sum, with the integral term left out when separated.
  always_comb begin
    acc = pisep_pkg::AccW'(prod.prod_p) + pisep_pkg::AccW'(prod.prod_d) +
          (prod.dropped ? '0 : pisep_pkg::AccW'(prod.prod_i));
  end

  // Arithmetic shift by 8 is a floor; saturate when the upper bits disagree.
  always_comb begin
    if (acc[pisep_pkg::AccW-1:pisep_pkg::DriveW+7] == '0 ||
        acc[pisep_pkg::AccW-1:pisep_pkg::DriveW+7] == '1) begin
      drive_next = acc[pisep_pkg::DriveW+7:8];
    end else if (acc[pisep_pkg::AccW-1]) begin
      drive_next = {1'b1, {(pisep_pkg::DriveW-1){1'b0}}};
    end else begin
      drive_next = {1'b0, {(pisep_pkg::DriveW-1){1'b1}}};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (up_ready) begin
      results.valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.drive            <= drive_next;
      results.integral_dropped <= prod.dropped;
    end
  end

endmodule
